FILE: rtl/core/mfc_pkg.sv
// Shared constants, codes and the result record of the meter frame checker.
package mfc_pkg;

    localparam logic [7:0] START_BYTE = 8'h68;
    localparam logic [7:0] END_BYTE   = 8'h16;

    // Frame layout: start, type, seven address bytes, control, length, data, sum, end.
    localparam int unsigned MIN_FRAME  = 13;
    localparam int unsigned HDR_LEN    = 11;
    localparam int unsigned LEN_POS    = 10;
    localparam int unsigned CTRL_POS   = 9;
    localparam int unsigned KIND_POS   = 1;
    localparam int unsigned ADDR_POS   = 2;
    localparam int unsigned ADDR_BYTES = 7;
    localparam int unsigned MIN_DATA   = 3;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_LENGTH   = 2'd1,
        STATUS_NO_END   = 2'd2,
        STATUS_CHECKSUM = 2'd3
    } status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  item_kind;
        logic [7:0]  data_byte;
        logic [7:0]  data_index;
        status_t     status;
        logic [7:0]  meter_kind;
        logic [55:0] meter_address;
        logic [7:0]  control_code;
        logic [7:0]  data_length;
        logic [15:0] data_ident;
        logic [7:0]  sequence_no;
    } result_t;

endpackage

FILE: rtl/core/mfc_in_if.sv
// Byte request channel of the meter frame checker.
interface mfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

FILE: rtl/core/mfc_out_if.sv
// Result channel of the meter frame checker.
interface mfc_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [1:0]  status;
    logic [7:0]  meter_kind;
    logic [55:0] meter_address;
    logic [7:0]  control_code;
    logic [7:0]  data_length;
    logic [15:0] data_ident;
    logic [7:0]  sequence_no;

    modport source (
        output valid, output item_kind, output data_byte, output data_index,
        output status, output meter_kind, output meter_address, output control_code,
        output data_length, output data_ident, output sequence_no, input ready
    );
    modport sink (
        input valid, input item_kind, input data_byte, input data_index,
        input status, input meter_kind, input meter_address, input control_code,
        input data_length, input data_ident, input sequence_no, output ready
    );
endinterface

FILE: rtl/core/mfc_tracker.sv
// Frame state, header capture, running sum and end-of-buffer checks.
module mfc_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic              end_of_buffer,
    output logic              has_result,
    output mfc_pkg::result_t  result
);

    logic        in_frame_reg, in_frame_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] last_reg, last_next;
    logic [7:0]  kind_reg, kind_next;
    logic [55:0] addr_reg, addr_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] ident_reg, ident_next;
    logic [7:0]  seq_reg, seq_next;

    logic        active;
    logic        have_data;
    logic [15:0] data_pos;
    logic [8:0]  frame_len;
    logic        length_bad;
    mfc_pkg::status_t status_code;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_next     = last_reg;
        kind_next     = kind_reg;
        addr_next     = addr_reg;
        ctrl_next     = ctrl_reg;
        len_next      = len_reg;
        ident_next    = ident_reg;
        seq_next      = seq_reg;
        have_data     = 1'b0;
        data_pos      = count_reg - 16'(mfc_pkg::HDR_LEN);

        active = in_frame_reg || (rx_byte == mfc_pkg::START_BYTE);

        if (active)
        begin
            in_frame_next = 1'b1;
            // The two newest bytes stay out of the sum: one of them may be the checksum.
            if (count_reg >= 16'd2)
            begin
                sum_next = sum_reg + last_reg[15:8];
            end
            last_next = {last_reg[7:0], rx_byte};

            if (count_reg < 16'(mfc_pkg::HDR_LEN))
            begin
                unique case (count_reg[3:0])
                    4'(mfc_pkg::KIND_POS): kind_next = rx_byte;
                    4'(mfc_pkg::CTRL_POS): ctrl_next = rx_byte;
                    4'(mfc_pkg::LEN_POS):  len_next  = rx_byte;
                    default:
                    begin
                        for (int i = 0; i < int'(mfc_pkg::ADDR_BYTES); i++)
                        begin
                            if (count_reg[3:0] == 4'(i + int'(mfc_pkg::ADDR_POS)))
                            begin
                                addr_next[8*i +: 8] = rx_byte;
                            end
                        end
                    end
                endcase
            end
            else if (data_pos < {8'h00, len_reg})
            begin
                have_data = 1'b1;
                if (data_pos == 16'd0)
                begin
                    ident_next[7:0] = rx_byte;
                end
                else if (data_pos == 16'd1)
                begin
                    ident_next[15:8] = rx_byte;
                end
                else if (data_pos == 16'd2)
                begin
                    seq_next = rx_byte;
                end
            end

            if (count_reg != 16'hFFFF)
            begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    // Checks on the frame as it stands after this byte, in priority order.
    always_comb
    begin
        frame_len  = {1'b0, len_next} + 9'(mfc_pkg::MIN_FRAME);
        length_bad = (count_next < 16'(mfc_pkg::MIN_FRAME)) ||
                     (count_next != {7'b0, frame_len});
        priority if (length_bad)
        begin
            status_code = mfc_pkg::STATUS_LENGTH;
        end
        else if (rx_byte != mfc_pkg::END_BYTE)
        begin
            status_code = mfc_pkg::STATUS_NO_END;
        end
        else if (sum_next != last_next[15:8])
        begin
            status_code = mfc_pkg::STATUS_CHECKSUM;
        end
        else if (len_next < 8'(mfc_pkg::MIN_DATA))
        begin
            status_code = mfc_pkg::STATUS_LENGTH;
        end
        else
        begin
            status_code = mfc_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        result     = '0;
        has_result = end_of_buffer || have_data;
        if (end_of_buffer)
        begin
            result.item_kind     = mfc_pkg::KIND_STATUS;
            result.status        = status_code;
            result.meter_kind    = kind_next;
            result.meter_address = addr_next;
            result.control_code  = ctrl_next;
            result.data_length   = len_next;
            result.data_ident    = ident_next;
            result.sequence_no   = seq_next;
        end
        else
        begin
            result.item_kind  = mfc_pkg::KIND_DATA;
            result.data_byte  = rx_byte;
            result.data_index = data_pos[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
            last_reg     <= '0;
            kind_reg     <= '0;
            addr_reg     <= '0;
            ctrl_reg     <= '0;
            len_reg      <= '0;
            ident_reg    <= '0;
            seq_reg      <= '0;
        end
        else if (step)
        begin
            if (end_of_buffer)
            begin
                in_frame_reg <= 1'b0;
                count_reg    <= '0;
                sum_reg      <= '0;
                last_reg     <= '0;
                kind_reg     <= '0;
                addr_reg     <= '0;
                ctrl_reg     <= '0;
                len_reg      <= '0;
                ident_reg    <= '0;
                seq_reg      <= '0;
            end
            else
            begin
                in_frame_reg <= in_frame_next;
                count_reg    <= count_next;
                sum_reg      <= sum_next;
                last_reg     <= last_next;
                kind_reg     <= kind_next;
                addr_reg     <= addr_next;
                ctrl_reg     <= ctrl_next;
                len_reg      <= len_next;
                ident_reg    <= ident_next;
                seq_reg      <= seq_next;
            end
        end
    end

    // The end of a buffer always returns the tracker to hunting.
    a_eob_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && end_of_buffer |=> !in_frame_reg && (count_reg == 16'd0))
        else $error("frame state not cleared after end of buffer");

    // Bytes are only counted inside a frame.
    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 16'd0) |-> in_frame_reg)
        else $error("byte count set while hunting");

    // A data result always lies inside the announced data field.
    a_data_in_field: assert property (@(posedge clk) disable iff (!rst_n)
        step && have_data |-> ({8'h00, result.data_index} < {8'h00, len_reg}) &&
                              (count_reg >= 16'(mfc_pkg::HDR_LEN)))
        else $error("data result outside the data field");

endmodule

FILE: rtl/core/meter_frame_checker.sv
// Top level of the meter frame checker: input register, frame tracker, result register.
//
// The meter frame checker takes a received buffer one byte per request and checks it
// as a meter frame: bytes before the first 0x68 start byte are skipped, the 11-byte
// header (type, seven address bytes, control, length L) is captured, and each of the
// L data bytes is returned as a data result together with its index in the data
// field. The request flagged as end of buffer returns one status result instead:
// header fields, the 16-bit data identifier, the sequence number and a status code
// (0 ok, 1 no frame or wrong length, 2 missing end byte, 3 checksum error). Requests
// that carry neither a data byte nor the end of the buffer return nothing. One
// request is taken every clock cycle while the byte channel is not stalled. A
// request waits in the input register while the tracker checks it, and its result
// is registered in the result register, which drives the result channel. The frame
// tracker updates its state once per request. When the result register holds an
// untaken result, a request that produces none still passes, while one that
// produces a result waits in the input register, so the byte channel stalls only
// after two results are held back.
module meter_frame_checker (
    input  logic   clk,
    input  logic   rst_n,
    mfc_in_if.sink    bytes,
    mfc_out_if.source results
);

    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_byte_reg;
    logic             s1_eob_reg;
    logic             out_valid_reg, out_valid_next;
    mfc_pkg::result_t out_reg;

    logic             has_result;
    mfc_pkg::result_t result;
    logic             out_free;
    logic             s1_fire;
    logic             in_take;

    mfc_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (s1_fire),
        .rx_byte       (s1_byte_reg),
        .end_of_buffer (s1_eob_reg),
        .has_result    (has_result),
        .result        (result)
    );

    // A request leaves the input register when it yields no result or the
    // result register is free or being emptied in this cycle.
    always_comb
    begin
        out_free    = !out_valid_reg || results.ready;
        s1_fire     = s1_valid_reg && (!has_result || out_free);
        bytes.ready = !s1_valid_reg || s1_fire;
        in_take     = bytes.valid && bytes.ready;

        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire && has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load without reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= bytes.rx_byte;
            s1_eob_reg  <= bytes.end_of_buffer;
        end
        if (s1_fire && has_result)
        begin
            out_reg <= result;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.item_kind     = out_reg.item_kind;
    assign results.data_byte     = out_reg.data_byte;
    assign results.data_index    = out_reg.data_index;
    assign results.status        = out_reg.status;
    assign results.meter_kind    = out_reg.meter_kind;
    assign results.meter_address = out_reg.meter_address;
    assign results.control_code  = out_reg.control_code;
    assign results.data_length   = out_reg.data_length;
    assign results.data_ident    = out_reg.data_ident;
    assign results.sequence_no   = out_reg.sequence_no;

    // A held-back request keeps its byte until the tracker takes it.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_byte_reg) &&
                                     $stable(s1_eob_reg))
        else $error("stalled request lost in the input register");

    // A new result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |-> !(s1_fire && has_result))
        else $error("result register overwritten while full");

    // An offered result stays valid and unchanged until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !results.ready |=> out_valid_reg && $stable(out_reg))
        else $error("offered result changed before it was taken");

endmodule
